### rtl/nps_pkg.sv
// shared types and constants of the nonpreemptive priority scheduler
package nps_pkg;

  localparam int PRIO_W     = 16;
  localparam int TIME_W     = 32;
  localparam int START_W    = 39;
  localparam int JOB_NUM_W  = 6;

  // one input item
  typedef struct packed {
    logic [PRIO_W-1:0] job_priority;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] service_time;
    logic              batch_last;
  } job_in_t;

  // one result item
  typedef struct packed {
    logic [JOB_NUM_W-1:0] job_number;
    logic [START_W-1:0]   start_time;
    logic                 result_last;
  } res_t;

  // word held per job in the job memory
  typedef struct packed {
    logic [PRIO_W-1:0] job_priority;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] service_time;
  } job_word_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_WAIT,
    ST_COMMIT,
    ST_EMIT
  } state_e;

endpackage

### rtl/nps_ram.sv
// generic simple dual port ram with registered read
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/nonpreemptive_priority_scheduler_unit.sv
// Loading: one item per cycle while busy_o is low; items past MAX_JOBS are dropped.
// After the item marked last (n jobs held) the block runs n rounds (scan, wait, commit),
// each round one scan of the job memory at one entry per cycle, then emits n results
// on consecutive cycles. Results cannot be stalled.
// The next batch may load from the last result's cycle on.
// Reset clears the job count, server clock and served marks; the memories are not cleared.
module nonpreemptive_priority_scheduler_unit #(
  parameter int MAX_JOBS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  nps_pkg::job_in_t job_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output nps_pkg::res_t    res_o
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);
  localparam int JW = $bits(nps_pkg::job_word_t);

  nps_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]             count_q, count_d;
  logic [IDX_W-1:0]             scan_q, scan_d;
  logic [IDX_W-1:0]             round_q, round_d;
  logic [nps_pkg::START_W-1:0]  clock_q, clock_d;
  logic [MAX_JOBS-1:0]          served_q, served_d;
  logic                         rvalid_q, rvalid_d;
  logic [IDX_W-1:0]             ridx_q, ridx_d;
  logic                         evalid_q, evalid_d;
  logic [IDX_W-1:0]             eidx_q, eidx_d;
  logic                         elast_q, elast_d;

  // tracker of the best job that has arrived: priority, then arrival
  logic                         have_a_q, have_a_d;
  logic [nps_pkg::PRIO_W-1:0]   a_prio_q, a_prio_d;
  logic [nps_pkg::TIME_W-1:0]   a_arr_q, a_arr_d;
  logic [nps_pkg::TIME_W-1:0]   a_svc_q, a_svc_d;
  logic [IDX_W-1:0]             a_idx_q, a_idx_d;
  // tracker of the earliest unserved job: arrival, then priority
  logic                         have_b_q, have_b_d;
  logic [nps_pkg::PRIO_W-1:0]   b_prio_q, b_prio_d;
  logic [nps_pkg::TIME_W-1:0]   b_arr_q, b_arr_d;
  logic [nps_pkg::TIME_W-1:0]   b_svc_q, b_svc_d;
  logic [IDX_W-1:0]             b_idx_q, b_idx_d;

  // memory ports
  logic                         job_we;
  nps_pkg::job_word_t           job_wdata, job_rdata;
  logic [JW-1:0]                job_rdata_raw;
  logic                         st_we;
  logic [nps_pkg::START_W-1:0]  st_rdata;

  // selection of the job committed this round
  logic [nps_pkg::START_W-1:0]  pick_start;
  logic [nps_pkg::TIME_W-1:0]   pick_svc;
  logic [IDX_W-1:0]             pick_idx;
  logic                         scan_last, round_last, arrived;

  assign job_wdata.job_priority = job_i.job_priority;
  assign job_wdata.arrival_time = job_i.arrival_time;
  assign job_wdata.service_time = job_i.service_time;
  assign job_rdata = nps_pkg::job_word_t'(job_rdata_raw);

  nps_ram #(
    .WIDTH(JW),
    .DEPTH(MAX_JOBS)
  ) u_job_ram (
    .clk_i  (clk_i),
    .we_i   (job_we),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(job_wdata),
    .raddr_i(scan_q),
    .rdata_o(job_rdata_raw)
  );

  nps_ram #(
    .WIDTH(nps_pkg::START_W),
    .DEPTH(MAX_JOBS)
  ) u_start_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(pick_idx),
    .wdata_i(pick_start),
    .raddr_i(scan_q),
    .rdata_o(st_rdata)
  );

  assign scan_last  = (CNT_W'(scan_q) + CNT_W'(1)) == count_q;
  assign round_last = (CNT_W'(round_q) + CNT_W'(1)) == count_q;
  assign arrived    = nps_pkg::START_W'(job_rdata.arrival_time) <= clock_q;

  // when nothing has arrived the clock jumps to the earliest arrival
  assign pick_start = have_a_q ? clock_q : nps_pkg::START_W'(b_arr_q);
  assign pick_svc   = have_a_q ? a_svc_q : b_svc_q;
  assign pick_idx   = have_a_q ? a_idx_q : b_idx_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nps_pkg::ST_LOAD;
      count_q  <= '0;
      scan_q   <= '0;
      round_q  <= '0;
      clock_q  <= '0;
      served_q <= '0;
      rvalid_q <= 1'b0;
      evalid_q <= 1'b0;
      have_a_q <= 1'b0;
      have_b_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      scan_q   <= scan_d;
      round_q  <= round_d;
      clock_q  <= clock_d;
      served_q <= served_d;
      rvalid_q <= rvalid_d;
      evalid_q <= evalid_d;
      have_a_q <= have_a_d;
      have_b_q <= have_b_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ridx_q   <= ridx_d;
    eidx_q   <= eidx_d;
    elast_q  <= elast_d;
    a_prio_q <= a_prio_d;
    a_arr_q  <= a_arr_d;
    a_svc_q  <= a_svc_d;
    a_idx_q  <= a_idx_d;
    b_prio_q <= b_prio_d;
    b_arr_q  <= b_arr_d;
    b_svc_q  <= b_svc_d;
    b_idx_q  <= b_idx_d;
  end

  // next state, scan evaluation and memory control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    scan_d   = scan_q;
    round_d  = round_q;
    clock_d  = clock_q;
    served_d = served_q;
    rvalid_d = (state_q == nps_pkg::ST_SCAN);
    ridx_d   = scan_q;
    evalid_d = (state_q == nps_pkg::ST_EMIT);
    eidx_d   = scan_q;
    elast_d  = scan_last;
    have_a_d = have_a_q;
    a_prio_d = a_prio_q;
    a_arr_d  = a_arr_q;
    a_svc_d  = a_svc_q;
    a_idx_d  = a_idx_q;
    have_b_d = have_b_q;
    b_prio_d = b_prio_q;
    b_arr_d  = b_arr_q;
    b_svc_d  = b_svc_q;
    b_idx_d  = b_idx_q;
    job_we   = 1'b0;
    st_we    = 1'b0;

    // compare the entry read last cycle; strict compares keep the lower index
    if (rvalid_q && !served_q[ridx_q]) begin
      if (arrived && (!have_a_q || job_rdata.job_priority < a_prio_q ||
          (job_rdata.job_priority == a_prio_q && job_rdata.arrival_time < a_arr_q))) begin
        have_a_d = 1'b1;
        a_prio_d = job_rdata.job_priority;
        a_arr_d  = job_rdata.arrival_time;
        a_svc_d  = job_rdata.service_time;
        a_idx_d  = ridx_q;
      end
      if (!have_b_q || job_rdata.arrival_time < b_arr_q ||
          (job_rdata.arrival_time == b_arr_q && job_rdata.job_priority < b_prio_q)) begin
        have_b_d = 1'b1;
        b_prio_d = job_rdata.job_priority;
        b_arr_d  = job_rdata.arrival_time;
        b_svc_d  = job_rdata.service_time;
        b_idx_d  = ridx_q;
      end
    end

    unique case (state_q)
      nps_pkg::ST_LOAD: begin
        if (start_i) begin
          if (count_q < MAX_CNT) begin
            job_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          if (job_i.batch_last) begin
            state_d = nps_pkg::ST_SCAN;
            scan_d  = '0;
            round_d = '0;
          end
        end
      end
      nps_pkg::ST_SCAN: begin
        if (scan_last) begin
          scan_d  = '0;
          state_d = nps_pkg::ST_WAIT;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      nps_pkg::ST_WAIT: begin
        state_d = nps_pkg::ST_COMMIT;
      end
      nps_pkg::ST_COMMIT: begin
        st_we              = 1'b1;
        served_d[pick_idx] = 1'b1;
        clock_d            = pick_start + nps_pkg::START_W'(pick_svc);
        have_a_d           = 1'b0;
        have_b_d           = 1'b0;
        if (round_last) begin
          state_d = nps_pkg::ST_EMIT;
        end else begin
          round_d = round_q + IDX_W'(1);
          state_d = nps_pkg::ST_SCAN;
        end
        scan_d = '0;
      end
      nps_pkg::ST_EMIT: begin
        if (scan_last) begin
          scan_d   = '0;
          count_d  = '0;
          clock_d  = '0;
          served_d = '0;
          state_d  = nps_pkg::ST_LOAD;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = nps_pkg::ST_LOAD;
      end
    endcase
  end

  // outputs
  assign busy_o            = (state_q != nps_pkg::ST_LOAD);
  assign res_valid_o       = evalid_q;
  assign res_o.job_number  = nps_pkg::JOB_NUM_W'(eidx_q);
  assign res_o.start_time  = st_rdata;
  assign res_o.result_last = elast_q;

endmodule

### rtl/nps_checker.sv
// port level checker of the scheduler and its bind
module nps_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input nps_pkg::job_in_t job_i,
  input logic             busy_o,
  input logic             res_valid_o,
  input nps_pkg::res_t    res_o
);

  // a last item starts scheduling
  a_last_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && job_i.batch_last) |=> busy_o)
    else $error("last item did not start scheduling");

  // an ordinary item keeps the block loading
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !job_i.batch_last) |=> !busy_o)
    else $error("block went busy on a non-last item");

  // results other than the final one come while busy
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.result_last) |-> busy_o)
    else $error("result shown while accepting items");

  // results are a gapless run in index order
  a_result_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.result_last) |=>
      (res_valid_o && res_o.job_number == $past(res_o.job_number) + 6'd1))
    else $error("result run broken or out of order");

  // a run begins at job zero
  a_run_begins_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> (res_o.job_number == 6'd0))
    else $error("result run did not begin at job zero");

endmodule

bind nonpreemptive_priority_scheduler_unit nps_checker u_nps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .job_i      (job_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

### sim/nonpreemptive_priority_scheduler_unit_tb.sv
// testbench of the nonpreemptive priority scheduler: directed and random batches against a predictor
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_unit_tb;

  localparam int JOB_SLOTS   = 64;
  localparam int TOTAL_ITEMS = 410;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYC  = 100;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  nps_pkg::job_in_t job_i = '0;
  logic             busy_o;
  logic             res_valid_o;
  nps_pkg::res_t    res_o;

  // predictor state
  logic [nps_pkg::PRIO_W-1:0]  job_prio    [JOB_SLOTS];
  logic [nps_pkg::TIME_W-1:0]  job_arrival [JOB_SLOTS];
  logic [nps_pkg::TIME_W-1:0]  job_service [JOB_SLOTS];
  logic [nps_pkg::START_W-1:0] job_start   [JOB_SLOTS];
  bit                          job_done    [JOB_SLOTS];
  int                          jobs_held = 0;
  logic [nps_pkg::START_W-1:0] server_time = '0;

  // start times still to come out of the block
  nps_pkg::res_t starts_due[$];

  int error_count = 0;
  int items_sent = 0;
  int items_dropped = 0;
  int batches_done = 0;
  int results_checked = 0;
  int idle_cycles = 0;

  // sender pacing
  int burst_left = 0;
  bit steady = 1'b0;

  nonpreemptive_priority_scheduler_unit #(
    .MAX_JOBS(JOB_SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .job_i      (job_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #6 clk_i = ~clk_i;

  // x is served before y: lower priority value, then earlier arrival, then lower index
  function automatic bit goes_first(int x, int y);
    if (job_prio[x] != job_prio[y]) return job_prio[x] < job_prio[y];
    if (job_arrival[x] != job_arrival[y]) return job_arrival[x] < job_arrival[y];
    return x < y;
  endfunction

  // single server without preemption over the held jobs
  function automatic void run_server();
    int pick;
    bit found;
    bit any_left;
    logic [nps_pkg::START_W-1:0] earliest;
    for (int r = 0; r < jobs_held; r++) begin
      any_left = 1'b0;
      earliest = '0;
      for (int i = 0; i < jobs_held; i++) begin
        if (!job_done[i] &&
            (!any_left || nps_pkg::START_W'(job_arrival[i]) < earliest)) begin
          earliest = nps_pkg::START_W'(job_arrival[i]);
          any_left = 1'b1;
        end
      end
      if (!any_left) break;
      // idle server jumps to the earliest pending arrival
      if (earliest > server_time) server_time = earliest;
      found = 1'b0;
      pick = 0;
      for (int i = 0; i < jobs_held; i++) begin
        if (job_done[i] || nps_pkg::START_W'(job_arrival[i]) > server_time) continue;
        if (!found || goes_first(i, pick)) begin
          pick = i;
          found = 1'b1;
        end
      end
      job_start[pick] = server_time;
      job_done[pick] = 1'b1;
      server_time = server_time + nps_pkg::START_W'(job_service[pick]);
    end
  endfunction

  // store one accepted job; the last one of a batch yields all start times
  function automatic void record_job(nps_pkg::job_in_t item);
    nps_pkg::res_t due;
    if (jobs_held < JOB_SLOTS) begin
      job_prio[jobs_held] = item.job_priority;
      job_arrival[jobs_held] = item.arrival_time;
      job_service[jobs_held] = item.service_time;
      job_done[jobs_held] = 1'b0;
      jobs_held++;
    end else begin
      items_dropped++;
    end
    if (item.batch_last) begin
      run_server();
      for (int i = 0; i < jobs_held; i++) begin
        due.job_number = nps_pkg::JOB_NUM_W'(i);
        due.start_time = job_start[i];
        due.result_last = (i == jobs_held - 1);
        starts_due.push_back(due);
      end
      for (int i = 0; i < JOB_SLOTS; i++) job_done[i] = 1'b0;
      jobs_held = 0;
      server_time = '0;
      batches_done++;
    end
  endfunction

  // send one item; entered and left at a falling edge, start_i stays high on return
  task automatic send_job(input logic [nps_pkg::PRIO_W-1:0] prio,
                          input logic [nps_pkg::TIME_W-1:0] arrival,
                          input logic [nps_pkg::TIME_W-1:0] service, input logic is_last);
    nps_pkg::job_in_t item;
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        start_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item.job_priority = prio;
    item.arrival_time = arrival;
    item.service_time = service;
    item.batch_last = is_last;
    job_i = item;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    record_job(item);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic stop_sender();
    start_i = 1'b0;
  endtask

  // field extremes, then a lone job with an idle jump
  task automatic test_extremes();
    steady = 1'b1;
    send_job(16'hFFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_job(16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_job(16'h0, 32'h0, 32'h0, 1'b0);
    send_job(16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_job(16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    stop_sender();
  endtask

  // equal priority resolved by arrival, then by index
  task automatic test_ties();
    steady = 1'b0;
    send_job(16'd5, 32'd10, 32'd3, 1'b0);
    send_job(16'd5, 32'd10, 32'd3, 1'b0);
    send_job(16'd5, 32'd4, 32'd3, 1'b0);
    send_job(16'd2, 32'd50, 32'd1, 1'b0);
    send_job(16'd5, 32'd10, 32'd0, 1'b1);
    stop_sender();
  endtask

  // server runs dry and the clock jumps forward
  task automatic test_idle_server();
    steady = 1'b1;
    send_job(16'd1, 32'd100, 32'd5, 1'b0);
    send_job(16'd0, 32'd10, 32'd5, 1'b0);
    send_job(16'd3, 32'd1000, 32'd2, 1'b0);
    send_job(16'd0, 32'd1000, 32'd7, 1'b1);
    stop_sender();
  endtask

  // an urgent job arriving mid-service waits for the running one
  task automatic test_no_preemption();
    steady = 1'b0;
    send_job(16'd9, 32'd0, 32'd50, 1'b0);
    send_job(16'd0, 32'd1, 32'd5, 1'b0);
    send_job(16'd0, 32'd2, 32'd5, 1'b0);
    send_job(16'd4, 32'd60, 32'd1, 1'b1);
    stop_sender();
  endtask

  // lone-job batches back to back, next batch loads as results drain
  task automatic test_back_to_back();
    steady = 1'b1;
    burst_left = 0;
    for (int i = 0; i < 3; i++) send_job(16'($urandom()), $urandom(), $urandom(), 1'b1);
    stop_sender();
  endtask

  // full batch with dropped items, the dropped last one starts scheduling
  task automatic test_full_batch();
    steady = 1'b0;
    for (int i = 0; i < JOB_SLOTS; i++)
      send_job(16'($urandom_range(0, 7)), $urandom_range(0, 200), $urandom_range(0, 30), 1'b0);
    send_job(16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_job(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_job(16'h0, 32'h0, 32'h0, 1'b1);
    // exactly full, last item still stored
    steady = 1'b1;
    for (int i = 0; i < JOB_SLOTS; i++)
      send_job(16'($urandom()), $urandom(), $urandom(), i == JOB_SLOTS - 1);
    stop_sender();
  endtask

  // random batches, mostly small, content shaped by a per-batch mode
  task automatic test_random_batches();
    int size;
    int mode;
    int pick;
    logic [nps_pkg::PRIO_W-1:0] prio;
    logic [nps_pkg::TIME_W-1:0] arrival;
    logic [nps_pkg::TIME_W-1:0] service;
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) size = $urandom_range(1, 6);
      else if (pick < 95) size = $urandom_range(7, 16);
      else size = $urandom_range(17, 40);
      mode = $urandom_range(0, 4);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < size; i++) begin
        case (mode)
          0: begin
            // heavy contention, many ties
            prio = 16'($urandom_range(0, 3));
            arrival = $urandom_range(0, 20);
            service = $urandom_range(0, 15);
          end
          1: begin
            // shared arrival times, priority nearly flat
            prio = 16'($urandom_range(0, 1));
            arrival = 32'($urandom_range(0, 3)) * 32'd7;
            service = $urandom_range(1, 10);
          end
          2: begin
            prio = 16'($urandom());
            arrival = $urandom();
            service = $urandom();
          end
          3: begin
            // sparse arrivals, short service: idle jumps
            prio = 16'($urandom_range(0, 7));
            arrival = $urandom_range(0, 1000);
            service = $urandom_range(0, 5);
          end
          default: begin
            // extremes mixed with random values
            case ($urandom_range(0, 2))
              0: prio = '0;
              1: prio = '1;
              default: prio = 16'($urandom());
            endcase
            case ($urandom_range(0, 2))
              0: arrival = '0;
              1: arrival = '1;
              default: arrival = $urandom();
            endcase
            case ($urandom_range(0, 2))
              0: service = '0;
              1: service = '1;
              default: service = $urandom();
            endcase
          end
        endcase
        send_job(prio, arrival, service, i == size - 1);
      end
    end
    stop_sender();
  endtask

  // compare each result with the oldest expected start time
  always @(posedge clk_i) begin
    nps_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      if (starts_due.size() == 0) begin
        $error("unexpected result: job_number %0d start_time %0d", res_o.job_number,
               res_o.start_time);
        error_count++;
      end else begin
        want = starts_due.pop_front();
        results_checked++;
        if (res_o.job_number !== want.job_number) begin
          $error("job_number: expected %0d, got %0d", want.job_number, res_o.job_number);
          error_count++;
        end
        if (res_o.start_time !== want.start_time) begin
          $error("start_time: expected %0d, got %0d", want.start_time, res_o.start_time);
          error_count++;
        end
        if (res_o.result_last !== want.result_last) begin
          $error("result_last: expected %0d, got %0d", want.result_last, res_o.result_last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item accepted in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || res_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_ties();
    test_idle_server();
    test_no_preemption();
    test_back_to_back();
    test_full_batch();
    test_random_batches();

    // drain outstanding start times, then watch for strays
    while (starts_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);

    $display("sent %0d items in %0d batches (%0d dropped past a full batch)", items_sent,
             batches_done, items_dropped);
    $display("checked %0d start times, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nonpreemptive_priority_scheduler_unit.sv
rtl/nps_checker.sv
sim/nonpreemptive_priority_scheduler_unit_tb.sv
